[design/lsepg_pkg.sv]
// ----------------------------------------------------------------------------
// lsepg_pkg
// Shared types and constants for the LED strip effect pixel generator.
// ----------------------------------------------------------------------------
package lsepg_pkg;

  localparam int unsigned CntW   = 9;
  localparam int unsigned CntMax = 511;
  localparam int unsigned ProgW  = 17;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ProgW-1:0] ProgOne  = 17'd65536;
  localparam logic [ProgW-1:0] ProgHalf = 17'd32768;

  typedef enum logic [1:0] {
    EffBlink  = 2'd0,
    EffOff    = 2'd1,
    EffWipe   = 2'd2,
    EffBounce = 2'd3
  } effect_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegEffectSelect = 4'd0,
    RegPixelCount   = 4'd1,
    RegStartRed     = 4'd2,
    RegStartGreen   = 4'd3,
    RegStartBlue    = 4'd4,
    RegEndRed       = 4'd5,
    RegEndGreen     = 4'd6,
    RegEndBlue      = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [ProgW-1:0] progress;
    logic [7:0]       pixel_index;
    logic [7:0]       prev_red;
    logic [7:0]       prev_green;
    logic [7:0]       prev_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    effect_e         effect_select;
    logic [CntW-1:0] pixel_count;
    logic [7:0]      start_red;
    logic [7:0]      start_green;
    logic [7:0]      start_blue;
    logic [7:0]      end_red;
    logic [7:0]      end_green;
    logic [7:0]      end_blue;
  } cfg_regs_t;

endpackage

[design/lsepg_stream_if.sv]
// ----------------------------------------------------------------------------
// lsepg_stream_if
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface lsepg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/lsepg_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lsepg_cfg_regs
// Configuration register file; one register written per write beat.
// ----------------------------------------------------------------------------
module lsepg_cfg_regs (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lsepg_stream_if.sink          cfg_i,
  output lsepg_pkg::cfg_regs_t  regs_o
);
  import lsepg_pkg::*;

  cfg_regs_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.effect_select <= EffOff;
      regs_q.pixel_count   <= CntW'(256);
      regs_q.start_red     <= 8'd0;
      regs_q.start_green   <= 8'd0;
      regs_q.start_blue    <= 8'd0;
      regs_q.end_red       <= 8'd0;
      regs_q.end_green     <= 8'd0;
      regs_q.end_blue      <= 8'd0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.index))
        RegEffectSelect: regs_q.effect_select <= effect_e'(cfg_i.data.wdata[1:0]);
        RegPixelCount:   regs_q.pixel_count   <= cfg_i.data.wdata[CntW-1:0];
        RegStartRed:     regs_q.start_red     <= cfg_i.data.wdata[7:0];
        RegStartGreen:   regs_q.start_green   <= cfg_i.data.wdata[7:0];
        RegStartBlue:    regs_q.start_blue    <= cfg_i.data.wdata[7:0];
        RegEndRed:       regs_q.end_red       <= cfg_i.data.wdata[7:0];
        RegEndGreen:     regs_q.end_green     <= cfg_i.data.wdata[7:0];
        RegEndBlue:      regs_q.end_blue      <= cfg_i.data.wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

[design/lsepg_color_calc.sv]
// ----------------------------------------------------------------------------
// lsepg_color_calc
// Per-pixel color logic for blink, off, wipe and bounce effects.
// ----------------------------------------------------------------------------
module lsepg_color_calc #(
  parameter int unsigned MAX_PIXELS = 256
) (
  input  lsepg_pkg::cfg_regs_t cfg_i,
  input  lsepg_pkg::pix_in_t   pix_i,
  output lsepg_pkg::pix_out_t  pix_o
);
  import lsepg_pkg::*;

  localparam int unsigned CntCap = (MAX_PIXELS > CntMax) ? CntMax : MAX_PIXELS;

  function automatic logic [7:0] blend(input logic [7:0] s, input logic [7:0] e,
                                       input logic [ProgW-1:0] t);
    logic signed [8:0]  diff;
    logic signed [26:0] prod;
    logic [10:0]        sum;
    diff = $signed({1'b0, e}) - $signed({1'b0, s});
    prod = diff * $signed({1'b0, t});
    sum  = {3'b000, s} + prod[26:16];
    return sum[7:0];
  endfunction

  // floor(x/3) for 8-bit x
  function automatic logic [7:0] div3(input logic [7:0] x);
    logic [15:0] m;
    m = {8'd0, x} * 16'd171;
    return {1'b0, m[15:9]};
  endfunction

  logic [CntW-1:0]  cnt, cnt_m1, idx9, wipe_last;
  logic [ProgW-1:0] prog, tri_t;
  logic [25:0]      wipe_prod;
  logic [9:0]       span, led_a, led, trail_gap;
  logic [26:0]      bnc_prod;
  logic [10:0]      pos;
  logic             in_strip;

  always_comb begin
    cnt      = (cfg_i.pixel_count > CntW'(CntCap)) ? CntW'(CntCap) : cfg_i.pixel_count;
    cnt_m1   = cnt - CntW'(1);
    idx9     = {1'b0, pix_i.pixel_index};
    in_strip = idx9 < cnt;
    prog     = (pix_i.progress > ProgOne) ? ProgOne : pix_i.progress;
    tri_t    = (prog <= ProgHalf) ? ProgW'(prog << 1) : ProgW'((ProgOne - prog) << 1);

    wipe_prod = 26'(cnt) * 26'(prog);
    wipe_last = (wipe_prod[25:16] > {1'b0, cnt_m1}) ? cnt_m1 : wipe_prod[24:16];

    span     = {cnt_m1, 1'b0};
    bnc_prod = 27'(span) * 27'(prog);
    pos      = bnc_prod[26:16];
    if (span == 10'd0) begin
      led_a = 10'd0;
    end else if (pos >= {1'b0, span}) begin
      led_a = 10'(pos - {1'b0, span});
    end else begin
      led_a = pos[9:0];
    end
    led       = (led_a > {1'b0, cnt_m1}) ? (span - led_a) : led_a;
    trail_gap = led - {2'b00, pix_i.pixel_index};

    pix_o.red_out   = pix_i.prev_red;
    pix_o.green_out = pix_i.prev_green;
    pix_o.blue_out  = pix_i.prev_blue;

    if (in_strip) begin
      case (cfg_i.effect_select)
        EffBlink: begin
          pix_o.red_out   = blend(cfg_i.start_red,   cfg_i.end_red,   tri_t);
          pix_o.green_out = blend(cfg_i.start_green, cfg_i.end_green, tri_t);
          pix_o.blue_out  = blend(cfg_i.start_blue,  cfg_i.end_blue,  tri_t);
        end
        EffOff: begin
          pix_o = '0;
        end
        EffWipe: begin
          if (idx9 <= wipe_last) begin
            pix_o.red_out   = cfg_i.end_red;
            pix_o.green_out = cfg_i.end_green;
            pix_o.blue_out  = cfg_i.end_blue;
          end
        end
        EffBounce: begin
          pix_o = '0;
          if ({2'b00, pix_i.pixel_index} <= led) begin
            case (trail_gap)
              10'd0, 10'd1: begin
                pix_o.red_out   = cfg_i.end_red;
                pix_o.green_out = cfg_i.end_green;
                pix_o.blue_out  = cfg_i.end_blue;
              end
              10'd2: begin
                pix_o.red_out   = {1'b0, cfg_i.end_red[7:1]};
                pix_o.green_out = {1'b0, cfg_i.end_green[7:1]};
                pix_o.blue_out  = {1'b0, cfg_i.end_blue[7:1]};
              end
              10'd3: begin
                pix_o.red_out   = div3(cfg_i.end_red);
                pix_o.green_out = div3(cfg_i.end_green);
                pix_o.blue_out  = div3(cfg_i.end_blue);
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[design/led_strip_effect_pixel_generator.sv]
// ----------------------------------------------------------------------------
// led_strip_effect_pixel_generator
// Pipeline: an input beat passes through the input register, the color logic
//   and the result register before its result beat is presented.
// Throughput: one pixel per cycle while out_o is ready, set by the single-pass color logic.
// Reset: clears both stage valid flags and loads the register reset values.
// ----------------------------------------------------------------------------
module led_strip_effect_pixel_generator #(
  parameter int unsigned MAX_PIXELS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lsepg_stream_if.sink   cfg_i,
  lsepg_stream_if.sink   in_i,
  lsepg_stream_if.source out_o
);
  import lsepg_pkg::*;

  cfg_regs_t regs;
  pix_in_t   in_data_q;
  pix_out_t  out_data_q, calc_out;
  logic      in_vld_q, in_vld_d, out_vld_q, out_vld_d, advance;

  lsepg_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  lsepg_color_calc #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_calc (
    .cfg_i (regs),
    .pix_i (in_data_q),
    .pix_o (calc_out)
  );

  assign advance     = !out_vld_q || out_o.ready;
  assign in_i.ready  = !in_vld_q || advance;
  assign in_vld_d    = in_i.ready ? in_i.valid : in_vld_q;
  assign out_vld_d   = advance ? in_vld_q : out_vld_q;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data;
    end
    if (advance && in_vld_q) begin
      out_data_q <= calc_out;
    end
  end

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !out_o.ready |=> in_vld_q && $stable(in_data_q))
    else $error("input stage lost a beat while output stalled");

  a_move_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && advance |=> out_vld_q)
    else $error("beat did not reach result register");

  a_drain_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_o.ready && !in_vld_q |=> !out_vld_q)
    else $error("result beat repeated");

endmodule
